FILE: design/bff_pkg.sv
// Shared types and constants for the byte-to-frame fragmenter.
// No dependencies; imported by every module of the block.
`default_nettype none

package bff_pkg;

  // fixed field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned DataW = 12;
  // width of bit-count arithmetic (frame width and byte bit count stay below 16)
  localparam int unsigned CalcW = 4;
  localparam logic [CalcW-1:0] ByteBitsC = CalcW'(ByteW);

  // byte held in the input stage, bits already reversed so the earliest is bit 0
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] rem;
    logic [CalcW-1:0] left;
    logic             last;
  } bff_work_t;

  // input stage control from the packer
  typedef struct packed {
    logic             done;
    logic             update;
    logic [ByteW-1:0] rem;
    logic [CalcW-1:0] left;
  } bff_ctrl_t;

  // one result request
  typedef struct packed {
    logic             head_frame;
    logic [DataW-1:0] frame_data;
    logic             message_end;
    logic             run_last;
  } bff_frame_t;

endpackage

`default_nettype wire

FILE: design/bff_in_stage.sv
// Input register of the fragmenter: holds the current byte, bit-reversed,
// with its count of unconsumed bits. Depends on bff_pkg.
`default_nettype none

module bff_in_stage
  import bff_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] byte_value_i,
  input  wire logic             last_byte_i,
  input  wire bff_ctrl_t        ctrl_i,
  output bff_work_t             work_o
);

  logic             valid_q, valid_d;
  logic [ByteW-1:0] rem_q, rem_d;
  logic [CalcW-1:0] left_q, left_d;
  logic             last_q, last_d;
  logic [ByteW-1:0] rev_byte;
  logic             accept;

  // free when empty or when the held byte finishes this cycle
  assign in_ready_o = !valid_q || ctrl_i.done;
  assign accept     = in_valid_i && in_ready_o;

  // msb-first byte becomes lsb-first bit stream
  always_comb begin
    for (int i = 0; i < ByteW; i++) begin
      rev_byte[i] = byte_value_i[ByteW-1-i];
    end
  end

  // next values
  always_comb begin
    valid_d = valid_q;
    rem_d   = rem_q;
    left_d  = left_q;
    last_d  = last_q;
    if (accept) begin
      valid_d = 1'b1;
      rem_d   = rev_byte;
      left_d  = ByteBitsC;
      last_d  = last_byte_i;
    end else if (ctrl_i.done) begin
      valid_d = 1'b0;
    end else if (ctrl_i.update) begin
      rem_d  = ctrl_i.rem;
      left_d = ctrl_i.left;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    left_q <= left_d;
    last_q <= last_d;
  end

  assign work_o = '{valid: valid_q, rem: rem_q, left: left_q, last: last_q};

endmodule

`default_nettype wire

FILE: design/bff_packer.sv
// Frame assembly: holds the partial frame and merges one run of byte bits
// per cycle while the result register is free, producing at most one frame per cycle. Depends on bff_pkg.
`default_nettype none

module bff_packer
  import bff_pkg::*;
#(
  parameter int unsigned FRAME_BITS = 12
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire bff_work_t work_i,
  input  wire logic      out_free_i,
  output bff_ctrl_t      ctrl_o,
  output logic           emit_o,
  output bff_frame_t     frame_o
);

  localparam int unsigned CntW = $clog2(FRAME_BITS + 1);
  localparam int unsigned ShW  = FRAME_BITS + ByteW;
  localparam int unsigned ExtW = FRAME_BITS + DataW;
  localparam logic [CalcW-1:0] FrameBitsC = CalcW'(FRAME_BITS);

  logic [FRAME_BITS-1:0] partial_q, partial_d;
  logic [CntW-1:0]       filled_q, filled_d;
  logic                  first_q, first_d;

  logic                  go;
  logic [CalcW-1:0]      filled_w, space, take, left_after;
  logic [ByteW:0]        mask_w;
  logic [ByteW-1:0]      chunk, rem_after;
  logic [ShW-1:0]        shifted, rem_ext;
  logic [FRAME_BITS-1:0] merged;
  logic [ExtW-1:0]       data_ext;
  logic                  full;

  assign go = work_i.valid && out_free_i;

  // take as many bits as fit in the current frame
  always_comb begin
    filled_w   = CalcW'(filled_q);
    space      = FrameBitsC - filled_w;
    take       = (work_i.left < space) ? work_i.left : space;
    mask_w     = ((ByteW+1)'(1) << take) - (ByteW+1)'(1);
    chunk      = work_i.rem & mask_w[ByteW-1:0];
    shifted    = ShW'(chunk) << filled_q;
    merged     = partial_q | shifted[FRAME_BITS-1:0];
    full       = (take == space);
    rem_after  = work_i.rem >> take;
    left_after = work_i.left - take;
    rem_ext    = ShW'(rem_after);
    data_ext   = ExtW'(merged);
  end

  // state update and result selection
  always_comb begin
    partial_d  = partial_q;
    filled_d   = filled_q;
    first_d    = first_q;
    emit_o     = 1'b0;
    ctrl_o     = '{done: 1'b0, update: 1'b0, rem: rem_after, left: left_after};
    frame_o    = '{head_frame: first_q, frame_data: data_ext[DataW-1:0],
                   message_end: 1'b0, run_last: 1'b0};
    if (go) begin
      if (full) begin
        emit_o  = 1'b1;
        first_d = 1'b0;
        if (left_after == '0) begin
          // byte ends on a frame boundary
          ctrl_o.done          = 1'b1;
          frame_o.run_last     = 1'b1;
          frame_o.message_end  = work_i.last;
          partial_d            = '0;
          filled_d             = '0;
          if (work_i.last) begin
            first_d = 1'b1;
          end
        end else if (!work_i.last && left_after < FrameBitsC) begin
          // leftover fits in the next frame: absorb it now
          ctrl_o.done      = 1'b1;
          frame_o.run_last = 1'b1;
          partial_d        = rem_ext[FRAME_BITS-1:0];
          filled_d         = CntW'(left_after);
        end else begin
          // more bits of the byte still to place
          ctrl_o.update = 1'b1;
          partial_d     = '0;
          filled_d      = '0;
        end
      end else begin
        // whole remainder of the byte fits without filling the frame
        ctrl_o.done = 1'b1;
        if (work_i.last) begin
          emit_o              = 1'b1;
          frame_o.message_end = 1'b1;
          frame_o.run_last    = 1'b1;
          partial_d           = '0;
          filled_d            = '0;
          first_d             = 1'b1;
        end else begin
          partial_d = merged;
          filled_d  = CntW'(filled_w + take);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      filled_q  <= '0;
      first_q   <= 1'b1;
    end else begin
      partial_q <= partial_d;
      filled_q  <= filled_d;
      first_q   <= first_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/bff_out_reg.sv
// Result register of the fragmenter: holds one frame until the sink takes it.
// Depends on bff_pkg.
`default_nettype none

module bff_out_reg
  import bff_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       emit_i,
  input  wire bff_frame_t frame_i,
  output logic            out_free_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output bff_frame_t      frame_o
);

  logic       valid_q, valid_d;
  bff_frame_t frame_q, frame_d;

  // a new frame may load when empty or when the held one leaves
  assign out_free_o = !valid_q || out_ready_i;

  always_comb begin
    frame_d = frame_q;
    if (emit_i) begin
      valid_d = 1'b1;
      frame_d = frame_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

  assign out_valid_o = valid_q;
  assign frame_o     = frame_q;

endmodule

`default_nettype wire

FILE: design/byte_to_fixed_frame_fragmenter.sv
// Byte-to-frame fragmenter top level. A request is registered in the input
// stage, merged into frames by bff_packer, and each frame is registered in the
// result register, from which it leaves when the sink takes it.
// Throughput: set by the single frame merge per cycle in bff_packer, held while the
// result register cannot load; a byte yielding at most one frame takes one merge.
// Reset: asynchronous active low; empties both registers, starts a new message.
`default_nettype none

module byte_to_fixed_frame_fragmenter
  import bff_pkg::*;
#(
  parameter int unsigned FRAME_BITS = 12
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] byte_value_i,
  input  wire logic             last_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  head_frame_o,
  output logic [DataW-1:0]      frame_data_o,
  output logic                  message_end_o,
  output logic                  run_last_o
);

  bff_work_t  work;
  bff_ctrl_t  ctrl;
  bff_frame_t frame_new, frame_out;
  logic       emit, out_free;

  // input register
  bff_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .byte_value_i(byte_value_i),
    .last_byte_i (last_byte_i),
    .ctrl_i      (ctrl),
    .work_o      (work)
  );

  // frame assembly
  bff_packer #(
    .FRAME_BITS(FRAME_BITS)
  ) u_pack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .work_i    (work),
    .out_free_i(out_free),
    .ctrl_o    (ctrl),
    .emit_o    (emit),
    .frame_o   (frame_new)
  );

  // result register
  bff_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .emit_i     (emit),
    .frame_i    (frame_new),
    .out_free_o (out_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .frame_o    (frame_out)
  );

  assign head_frame_o  = frame_out.head_frame;
  assign frame_data_o  = frame_out.frame_data;
  assign message_end_o = frame_out.message_end;
  assign run_last_o    = frame_out.run_last;

endmodule

`default_nettype wire

FILE: design/bff_checker.sv
// Port-level checks for the byte-to-frame fragmenter, bound to the top level.
// Depends on bff_pkg and byte_to_fixed_frame_fragmenter.
`default_nettype none

module bff_checker
  import bff_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic             head_frame_o,
  input wire logic [DataW-1:0] frame_data_o,
  input wire logic             message_end_o,
  input wire logic             run_last_o
);

  // stalled result stays valid
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  // stalled result keeps its payload
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(frame_data_o) && $stable(head_frame_o))
    else $error("result payload changed while stalled");

  // a message always ends on the last frame of its byte
  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_end_o |-> run_last_o)
    else $error("message end without run end");

  // the frame after a message end opens the next message
  a_first_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && message_end_o |=> !out_valid_o || head_frame_o)
    else $error("frame after message end not marked first");

  // inside a message only the opening frame is marked first
  a_no_first_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !message_end_o |=> !out_valid_o || !head_frame_o)
    else $error("first frame marked inside a message");

endmodule

bind byte_to_fixed_frame_fragmenter bff_checker u_bff_checker (.*);

`default_nettype wire
